[src/pds_pkg.sv]
// Package for the PLL divider search: register indexes, defaults and shared types.
package pds_pkg;

   // Search limits for the three code counters
   localparam int MULT_CODE_MAX_DEF = 30;
   localparam int PRE_CODE_MAX_DEF  = 30;
   localparam int POST_CODE_MAX_DEF = 3;

   // Configuration port geometry
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REF_FREQ   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VCO_MIN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_VCO_MAX    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_MIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_MAX = 3'd4;

   // Register reset values
   localparam logic [5:0] REF_FREQ_RST   = 6'd12;
   localparam logic [9:0] VCO_MIN_RST    = 10'd280;
   localparam logic [9:0] VCO_MAX_RST    = 10'd550;
   localparam logic [7:0] TARGET_MIN_RST = 8'd5;
   localparam logic [7:0] TARGET_MAX_RST = 8'd120;

   // Register file contents
   typedef struct packed {
      logic [5:0] ref_freq;
      logic [9:0] vco_min;
      logic [9:0] vco_max;
      logic [7:0] target_min;
      logic [7:0] target_max;
   } cfg_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic step;
      logic capture_hit;
      logic capture_miss;
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic in_range;
      logic match;
      logic last;
   } status_type;

   // Controller states
   typedef enum logic [2:0] {
      ST_IDLE    = 3'b001,
      ST_SEARCH  = 3'b010,
      ST_RESPOND = 3'b100
   } state_type;

endpackage

[src/pll_divider_search.sv]
// Top level of the PLL divider search: register file, controller and datapath.
//
// Pulse start while busy is low to submit target_mhz. A target outside the
// target window answers in the cycle right after the accepting edge. Otherwise
// the datapath tries one (post, pre, mult) candidate per cycle, mult innermost,
// and stops on the first hit, or with a miss after the last candidate. Each
// candidate is checked by the single compare unit fed from running-sum
// registers, and the word is presented in ST_RESPOND. The result word appears
// for exactly one cycle with rsp_strobe high and is not held: the receiver
// must take it then. busy stays high until the strobe cycle has passed. Write
// configuration only while busy is low.
module pll_divider_search #(
   parameter int MULT_CODE_MAX = pds_pkg::MULT_CODE_MAX_DEF,
   parameter int PRE_CODE_MAX  = pds_pkg::PRE_CODE_MAX_DEF,
   parameter int POST_CODE_MAX = pds_pkg::POST_CODE_MAX_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [pds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pds_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           start,
   output logic                           busy,
   input  logic [7:0]                     req_target_mhz,
   output logic                           rsp_strobe,
   output logic                           rsp_found,
   output logic [4:0]                     rsp_mult_code,
   output logic [4:0]                     rsp_pre_code,
   output logic [1:0]                     rsp_post_code
);

   pds_pkg::cfg_type    cfg;
   pds_pkg::cmd_type    cmd;
   pds_pkg::status_type status;

   pds_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   pds_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .status     (status),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   pds_datapath #(
      .MULT_CODE_MAX (MULT_CODE_MAX),
      .PRE_CODE_MAX  (PRE_CODE_MAX),
      .POST_CODE_MAX (POST_CODE_MAX)
   ) u_datapath (
      .clock          (clock),
      .cfg            (cfg),
      .req_target_mhz (req_target_mhz),
      .cmd            (cmd),
      .status         (status),
      .rsp_found      (rsp_found),
      .rsp_mult_code  (rsp_mult_code),
      .rsp_pre_code   (rsp_pre_code),
      .rsp_post_code  (rsp_post_code)
   );

   // Result strobe lasts a single cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held longer than one cycle");

   // A miss reports all codes zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_found) |->
         (rsp_mult_code == 5'd0 && rsp_pre_code == 5'd0 && rsp_post_code == 2'd0))
      else $error("miss reported with nonzero codes");

   // An accepted word makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted word did not raise busy");

   // The strobe only comes while busy
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> busy)
      else $error("result strobe outside a busy period");

endmodule

[src/pds_csr.sv]
// Configuration register file for the PLL divider search.
module pds_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_en,
   input  logic [pds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pds_pkg::CSR_DATA_W-1:0] csr_wdata,
   output pds_pkg::cfg_type               cfg
);

   pds_pkg::cfg_type cfg_ff;

   // Write the addressed register; drop writes to unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ref_freq   <= pds_pkg::REF_FREQ_RST;
         cfg_ff.vco_min    <= pds_pkg::VCO_MIN_RST;
         cfg_ff.vco_max    <= pds_pkg::VCO_MAX_RST;
         cfg_ff.target_min <= pds_pkg::TARGET_MIN_RST;
         cfg_ff.target_max <= pds_pkg::TARGET_MAX_RST;
      end else if (csr_write_en) begin
         unique case (csr_index)
            pds_pkg::CSR_REF_FREQ:   cfg_ff.ref_freq   <= csr_wdata[5:0];
            pds_pkg::CSR_VCO_MIN:    cfg_ff.vco_min    <= csr_wdata[9:0];
            pds_pkg::CSR_VCO_MAX:    cfg_ff.vco_max    <= csr_wdata[9:0];
            pds_pkg::CSR_TARGET_MIN: cfg_ff.target_min <= csr_wdata[7:0];
            pds_pkg::CSR_TARGET_MAX: cfg_ff.target_max <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/pds_datapath.sv]
// Datapath of the PLL divider search: code counters, running products, result word.
module pds_datapath #(
   parameter int MULT_CODE_MAX = pds_pkg::MULT_CODE_MAX_DEF,
   parameter int PRE_CODE_MAX  = pds_pkg::PRE_CODE_MAX_DEF,
   parameter int POST_CODE_MAX = pds_pkg::POST_CODE_MAX_DEF
) (
   input  logic                 clock,
   input  pds_pkg::cfg_type     cfg,
   input  logic [7:0]           req_target_mhz,
   input  pds_pkg::cmd_type     cmd,
   output pds_pkg::status_type  status,
   output logic                 rsp_found,
   output logic [4:0]           rsp_mult_code,
   output logic [4:0]           rsp_pre_code,
   output logic [1:0]           rsp_post_code
);

   localparam int MW = $clog2(MULT_CODE_MAX + 1);
   localparam int PW = $clog2(PRE_CODE_MAX + 1);
   localparam int DW = (POST_CODE_MAX > 0) ? $clog2(POST_CODE_MAX + 1) : 1;
   // Wide enough for 2*ref*(m+1), vco*(p+1) and target*(d+1)*(p+1)
   localparam int CW = 10 + $clog2(MULT_CODE_MAX + 2) + $clog2(PRE_CODE_MAX + 2)
                       + $clog2(POST_CODE_MAX + 2);

   logic [MW-1:0] m_ff, m_in;
   logic [PW-1:0] p_ff, p_in;
   logic [DW-1:0] d_ff, d_in;
   logic [7:0]    target_ff, target_in;
   logic [CW-1:0] num_ff, num_in;    // 2*ref*(m+1)
   logic [CW-1:0] lo_ff, lo_in;      // vco_min*(p+1)
   logic [CW-1:0] hi_ff, hi_in;      // vco_max*(p+1)
   logic [CW-1:0] td_ff, td_in;      // target*(d+1)
   logic [CW-1:0] want_ff, want_in;  // target*(d+1)*(p+1)

   logic          found_ff, found_in;
   logic [4:0]    mult_ff, mult_in;
   logic [4:0]    pre_ff, pre_in;
   logic [1:0]    post_ff, post_in;

   logic [CW-1:0] two_ref;
   logic [CW-1:0] vmin_w;
   logic [CW-1:0] vmax_w;
   logic [CW-1:0] tgt_w;
   logic          m_last, p_last, d_last;

   assign two_ref = CW'({cfg.ref_freq, 1'b0});
   assign vmin_w  = CW'(cfg.vco_min);
   assign vmax_w  = CW'(cfg.vco_max);
   assign tgt_w   = CW'(target_ff);

   assign m_last = (m_ff == MW'(MULT_CODE_MAX));
   assign p_last = (p_ff == PW'(PRE_CODE_MAX));
   assign d_last = (d_ff == DW'(POST_CODE_MAX));

   // Status toward the controller
   always_comb begin
      status.in_range = (req_target_mhz >= cfg.target_min) &&
                        (req_target_mhz <= cfg.target_max);
      status.match    = (num_ff >= lo_ff) && (num_ff <= hi_ff) && (num_ff == want_ff);
      status.last     = m_last && p_last && d_last;
   end

   // Advance the candidate triple, m innermost, d outermost
   always_comb begin
      m_in      = m_ff;
      p_in      = p_ff;
      d_in      = d_ff;
      target_in = target_ff;
      num_in    = num_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      td_in     = td_ff;
      want_in   = want_ff;
      if (cmd.load) begin
         m_in      = '0;
         p_in      = '0;
         d_in      = '0;
         target_in = req_target_mhz;
         num_in    = two_ref;
         lo_in     = vmin_w;
         hi_in     = vmax_w;
         td_in     = CW'(req_target_mhz);
         want_in   = CW'(req_target_mhz);
      end else if (cmd.step) begin
         if (!m_last) begin
            m_in   = m_ff + MW'(1);
            num_in = num_ff + two_ref;
         end else begin
            m_in   = '0;
            num_in = two_ref;
            if (!p_last) begin
               p_in    = p_ff + PW'(1);
               lo_in   = lo_ff + vmin_w;
               hi_in   = hi_ff + vmax_w;
               want_in = want_ff + td_ff;
            end else begin
               p_in    = '0;
               lo_in   = vmin_w;
               hi_in   = vmax_w;
               d_in    = d_ff + DW'(1);
               td_in   = td_ff + tgt_w;
               want_in = td_ff + tgt_w;
            end
         end
      end
   end

   // Latch the result word
   always_comb begin
      found_in = found_ff;
      mult_in  = mult_ff;
      pre_in   = pre_ff;
      post_in  = post_ff;
      if (cmd.capture_hit) begin
         found_in = 1'b1;
         mult_in  = 5'(m_ff);
         pre_in   = 5'(p_ff);
         post_in  = 2'(d_ff);
      end else if (cmd.capture_miss) begin
         found_in = 1'b0;
         mult_in  = '0;
         pre_in   = '0;
         post_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      m_ff      <= m_in;
      p_ff      <= p_in;
      d_ff      <= d_in;
      target_ff <= target_in;
      num_ff    <= num_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      td_ff     <= td_in;
      want_ff   <= want_in;
      found_ff  <= found_in;
      mult_ff   <= mult_in;
      pre_ff    <= pre_in;
      post_ff   <= post_in;
   end

   assign rsp_found     = found_ff;
   assign rsp_mult_code = mult_ff;
   assign rsp_pre_code  = pre_ff;
   assign rsp_post_code = post_ff;

endmodule

[src/pds_ctrl.sv]
// Controller of the PLL divider search: sequences load, search steps and the result strobe.
module pds_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  pds_pkg::status_type status,
   output pds_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                rsp_strobe
);

   pds_pkg::state_type state_ff, state_in;

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         pds_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (status.in_range) begin
                  state_in = pds_pkg::ST_SEARCH;
               end else begin
                  cmd.capture_miss = 1'b1;
                  state_in         = pds_pkg::ST_RESPOND;
               end
            end
         end
         pds_pkg::ST_SEARCH: begin
            priority if (status.match) begin
               cmd.capture_hit = 1'b1;
               state_in        = pds_pkg::ST_RESPOND;
            end else if (status.last) begin
               cmd.capture_miss = 1'b1;
               state_in         = pds_pkg::ST_RESPOND;
            end else begin
               cmd.step = 1'b1;
            end
         end
         pds_pkg::ST_RESPOND: begin
            state_in = pds_pkg::ST_IDLE;
         end
         default: begin
            state_in = pds_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pds_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != pds_pkg::ST_IDLE);
   assign rsp_strobe = (state_ff == pds_pkg::ST_RESPOND);

endmodule

[tb/pll_divider_search_tb.sv]
// Self-checking testbench for pll_divider_search: queue-fed driver, predictor and monitor.
module pll_divider_search_tb;
   import pds_pkg::*;

   // Word kinds held in the pending stimulus queue
   typedef enum logic [1:0] {
      ITEM_TARGET,
      ITEM_CSR,
      ITEM_DRAIN
   } item_kind_t;

   typedef struct {
      item_kind_t                kind;
      logic [7:0]                target;
      logic [CSR_IDX_W-1:0]      idx;
      logic [CSR_DATA_W-1:0]     data;
      int                        gap;
   } stim_word_t;

   typedef struct packed {
      logic       found;
      logic [4:0] mult;
      logic [4:0] pre;
      logic [1:0] post;
   } pll_codes_t;

   localparam int DRAIN_SETTLE = 4;
   localparam int MAX_REPORTS  = 10;
   localparam logic [CSR_IDX_W-1:0] CSR_IDX_LAST = '1;

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index      = '0;
   logic [CSR_DATA_W-1:0] csr_wdata      = '0;
   logic                  start          = 1'b0;
   logic [7:0]            req_target_mhz = '0;
   logic                  busy;
   logic                  rsp_strobe;
   logic                  rsp_found;
   logic [4:0]            rsp_mult_code;
   logic [4:0]            rsp_pre_code;
   logic [1:0]            rsp_post_code;

   stim_word_t  stim_q[$];
   pll_codes_t  codes_q[$];
   cfg_type     cfg_model;
   logic        req_taken = 1'b0;
   int          hold_cnt = 0;
   int          drive_gap = 0;
   int          burst_left = 0;
   int          mismatch_cnt = 0;

   pll_divider_search u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .start          (start),
      .busy           (busy),
      .req_target_mhz (req_target_mhz),
      .rsp_strobe     (rsp_strobe),
      .rsp_found      (rsp_found),
      .rsp_mult_code  (rsp_mult_code),
      .rsp_pre_code   (rsp_pre_code),
      .rsp_post_code  (rsp_post_code)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Walk post, pre, mult in order and return the first exact hit
   function automatic pll_codes_t search_codes(input cfg_type c, input logic [7:0] t);
      pll_codes_t w;
      int         lo, hi, want, num;
      w = '0;
      if (t < c.target_min || t > c.target_max) return w;
      for (int d = 0; d <= POST_CODE_MAX_DEF; d++) begin
         for (int p = 0; p <= PRE_CODE_MAX_DEF; p++) begin
            lo   = int'(c.vco_min) * (p + 1);
            hi   = int'(c.vco_max) * (p + 1);
            want = int'(t) * (d + 1) * (p + 1);
            for (int m = 0; m <= MULT_CODE_MAX_DEF; m++) begin
               num = 2 * int'(c.ref_freq) * (m + 1);
               if (num >= lo && num <= hi && num == want) begin
                  w.found = 1'b1;
                  w.mult  = 5'(m);
                  w.pre   = 5'(p);
                  w.post  = 2'(d);
                  return w;
               end
            end
         end
      end
      return w;
   endfunction

   // Queue one target word; the first word of each random-length burst carries a gap
   task automatic push_target(input logic [7:0] t);
      stim_word_t s;
      s.kind   = ITEM_TARGET;
      s.target = t;
      s.idx    = '0;
      s.data   = '0;
      if (burst_left == 0) begin
         s.gap      = $urandom_range(1, 24);
         burst_left = $urandom_range(1, 8);
      end else begin
         s.gap = 0;
      end
      burst_left--;
      stim_q.push_back(s);
   endtask

   task automatic push_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      stim_word_t s;
      s.kind   = ITEM_CSR;
      s.target = '0;
      s.idx    = idx;
      s.data   = data;
      s.gap    = 0;
      stim_q.push_back(s);
   endtask

   // Wait until all results are in, then program every register
   task automatic push_config(input logic [9:0] rf, input logic [9:0] vmin, input logic [9:0] vmax,
                              input logic [9:0] tmin, input logic [9:0] tmax);
      stim_word_t s;
      s.kind   = ITEM_DRAIN;
      s.target = '0;
      s.idx    = '0;
      s.data   = '0;
      s.gap    = 0;
      stim_q.push_back(s);
      push_csr(CSR_REF_FREQ, rf);
      push_csr(CSR_VCO_MIN, vmin);
      push_csr(CSR_VCO_MAX, vmax);
      push_csr(CSR_TARGET_MIN, tmin);
      push_csr(CSR_TARGET_MAX, tmax);
   endtask

   // Driver: change inputs on the falling edge, one assignment per signal
   always @(negedge clock) begin
      logic                  nxt_start;
      logic                  nxt_we;
      logic [7:0]            nxt_target;
      logic [CSR_IDX_W-1:0]  nxt_idx;
      logic [CSR_DATA_W-1:0] nxt_data;
      nxt_start  = start;
      nxt_we     = 1'b0;
      nxt_target = req_target_mhz;
      nxt_idx    = csr_index;
      nxt_data   = csr_wdata;
      if (reset) begin
         nxt_start = 1'b0;
      end else begin
         if (start && req_taken) begin
            nxt_start = 1'b0;
            hold_cnt  = drive_gap;
         end
         if (!nxt_start) begin
            if (hold_cnt > 0) begin
               hold_cnt--;
            end else if (stim_q.size() > 0) begin
               case (stim_q[0].kind)
                  ITEM_TARGET: begin
                     nxt_start  = 1'b1;
                     nxt_target = stim_q[0].target;
                     drive_gap  = stim_q[0].gap;
                     void'(stim_q.pop_front());
                  end
                  ITEM_CSR: begin
                     nxt_we   = 1'b1;
                     nxt_idx  = stim_q[0].idx;
                     nxt_data = stim_q[0].data;
                     void'(stim_q.pop_front());
                  end
                  default: begin
                     if (codes_q.size() == 0 && !busy) begin
                        hold_cnt = DRAIN_SETTLE;
                        void'(stim_q.pop_front());
                     end
                  end
               endcase
            end
         end
      end
      start          <= nxt_start;
      csr_write_en   <= nxt_we;
      req_target_mhz <= nxt_target;
      csr_index      <= nxt_idx;
      csr_wdata      <= nxt_data;
   end

   // Monitor: track config, predict on accept, check each strobed word
   always @(posedge clock) begin
      pll_codes_t got;
      pll_codes_t want;
      if (reset) begin
         cfg_model.ref_freq   <= REF_FREQ_RST;
         cfg_model.vco_min    <= VCO_MIN_RST;
         cfg_model.vco_max    <= VCO_MAX_RST;
         cfg_model.target_min <= TARGET_MIN_RST;
         cfg_model.target_max <= TARGET_MAX_RST;
         req_taken            <= 1'b0;
      end else begin
         req_taken <= start && !busy;
         if (csr_write_en) begin
            case (csr_index)
               CSR_REF_FREQ:   cfg_model.ref_freq   <= csr_wdata[5:0];
               CSR_VCO_MIN:    cfg_model.vco_min    <= csr_wdata;
               CSR_VCO_MAX:    cfg_model.vco_max    <= csr_wdata;
               CSR_TARGET_MIN: cfg_model.target_min <= csr_wdata[7:0];
               CSR_TARGET_MAX: cfg_model.target_max <= csr_wdata[7:0];
               default: ;
            endcase
         end
         if (start && !busy) codes_q.push_back(search_codes(cfg_model, req_target_mhz));
         if (rsp_strobe) begin
            got = '{rsp_found, rsp_mult_code, rsp_pre_code, rsp_post_code};
            if (codes_q.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= MAX_REPORTS)
                  $display("unexpected word: found=%0d mult=%0d pre=%0d post=%0d",
                           got.found, got.mult, got.pre, got.post);
            end else begin
               want = codes_q.pop_front();
               if (got.found !== want.found || got.mult !== want.mult ||
                   got.pre !== want.pre || got.post !== want.post) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= MAX_REPORTS)
                     $display("mismatch: exp found=%0d mult=%0d pre=%0d post=%0d, got found=%0d mult=%0d pre=%0d post=%0d",
                              want.found, want.mult, want.pre, want.post,
                              got.found, got.mult, got.pre, got.post);
               end
            end
         end
      end
   end

   // Stimulus, then wait for the last word and report
   initial begin
      int rf, vmin, vmax, tmin, tmax;

      // defaults after reset: window edges and a few plain targets
      push_target(8'd0);
      push_target(8'd4);
      push_target(8'd5);
      push_target(8'd120);
      push_target(8'd121);
      push_target(8'd255);
      push_target(8'd100);
      push_target(8'd48);

      // widest windows, reference set to 50, plus ignored indexes
      push_config(10'd50, 10'd0, 10'd1023, 10'd0, 10'd255);
      for (int i = int'(CSR_TARGET_MAX) + 1; i <= int'(CSR_IDX_LAST); i++)
         push_csr(CSR_IDX_W'(i), 10'h3FF);
      push_target(8'd0);
      push_target(8'd255);
      push_target(8'd1);
      push_target(8'd25);

      // zero reference: only a zero target can hit
      push_config(10'd0, 10'd0, 10'd1023, 10'd0, 10'd255);
      push_target(8'd0);
      push_target(8'd7);

      // inverted oscillator bounds
      push_config(10'd12, 10'd600, 10'd300, 10'd0, 10'd255);
      push_target(8'd50);

      // inverted target window
      push_config(10'd12, 10'd280, 10'd550, 10'd200, 10'd10);
      push_target(8'd100);
      push_target(8'd200);
      push_target(8'd10);

      // oversized register data gets masked
      push_config(10'h3FF, 10'd280, 10'd550, 10'h305, 10'h3FF);
      push_target(8'd63);
      push_target(8'd126);

      // random phases: mostly sane settings and in-window targets
      for (int ph = 0; ph < 6; ph++) begin
         rf   = $urandom_range(1, 50);
         vmin = $urandom_range(0, 600);
         vmax = vmin + $urandom_range(0, 423);
         tmin = $urandom_range(0, 60);
         tmax = $urandom_range(tmin, 255);
         if ($urandom_range(0, 7) == 0) rf = $urandom_range(0, 1023);
         if ($urandom_range(0, 7) == 0) vmax = $urandom_range(0, 1023);
         if ($urandom_range(0, 7) == 0) tmin = $urandom_range(0, 1023);
         push_config(10'(rf), 10'(vmin), 10'(vmax), 10'(tmin), 10'(tmax));
         if ($urandom_range(0, 3) == 0)
            push_csr(CSR_IDX_W'($urandom_range(int'(CSR_TARGET_MAX) + 1, int'(CSR_IDX_LAST))),
                     CSR_DATA_W'($urandom));
         for (int k = 0; k < 25; k++) begin
            if ($urandom_range(0, 4) == 0)
               push_target(8'($urandom_range(0, 255)));
            else
               push_target(8'($urandom_range(tmin % 256, tmax)));
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (stim_q.size() != 0 || codes_q.size() != 0 || start || busy)
         @(negedge clock);
      repeat (8) @(posedge clock);
      if (mismatch_cnt == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Hard stop in case the block stops answering
   initial begin
      #12000000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
